[sv/wmas_pkg.sv]
// Package for the windowed minimum-after-start unit.
// Holds result types, queue sizing and the index saturation limit.
// No dependencies.
package wmas_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam logic [15:0] IDX_CAP =
        (MAX_SAMPLES - 1 > 65535) ? 16'hFFFF : 16'(MAX_SAMPLES - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] index;
        logic [9:0]  glucose;
        logic        valid;
    } t_best;

    typedef struct packed {
        logic        last;
        logic        found_valid;
        logic [9:0]  min_glucose;
        logic [15:0] min_index;
    } t_result;

    // running minimum update; strict compare keeps the earliest on ties
    function automatic t_best take_sample(t_best b, logic [15:0] idx,
                                          logic [9:0] g, logic v);
        t_best r;
        r = b;
        if (v && (!b.valid || g < b.glucose)) begin
            r.glucose = g;
            r.valid   = 1'b1;
            r.index   = idx;
        end
        return r;
    endfunction

    function automatic t_result make_result(t_best b, logic last);
        t_result r;
        r.last        = last;
        r.found_valid = b.valid;
        r.min_glucose = b.valid ? b.glucose : 10'd0;
        r.min_index   = b.index;
        return r;
    endfunction

endpackage

[sv/windowed_min_after_start_unit.sv]
// Windowed minimum-after-start unit, top level; uses wmas_pkg, wmas_core, wmas_out_fifo.
// Results are written to the output queue at the input transfer edge.
// Throughput: one sample per cycle while the queue keeps room for two results;
// output drains one result per cycle while m_axis_tready is high, so the queue depth sets stall behavior.
// Reset: synchronous active-low; clears window state, index and queue,
// and loads window_seconds with 14400.
module windowed_min_after_start_unit import wmas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_time[31:0], glucose[41:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // glucose_valid[0], is_start[1]
    input  logic        s_axis_tlast,   // series_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // min_index[15:0], min_glucose[25:16],
                                        // found_valid[26], zero pad
    output logic        m_axis_tlast    // last_in_run
);

    t_result    res0;
    t_result    res1;
    t_result    head;
    logic [1:0] res_cnt;
    logic       room2;
    logic       accept;

    assign accept        = s_axis_tvalid && room2;
    assign s_axis_tready = room2;

    wmas_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_sample_time   (s_axis_tdata[31:0]),
        .i_glucose       (s_axis_tdata[41:32]),
        .i_glucose_valid (s_axis_tuser[0]),
        .i_is_start      (s_axis_tuser[1]),
        .i_series_end    (s_axis_tlast),
        .o_res0          (res0),
        .o_res1          (res1),
        .o_res_cnt       (res_cnt)
    );

    wmas_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_push_cnt (res_cnt),
        .o_room2    (room2),
        .o_valid    (m_axis_tvalid),
        .o_data     (head),
        .i_pop      (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, head.found_valid, head.min_glucose, head.min_index};
    assign m_axis_tlast = head.last;

endmodule

[sv/wmas_core.sv]
// Window tracking and running minimum; produces up to two results per transfer.
// Depends on wmas_pkg.
module wmas_core import wmas_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [19:0]   i_cfg_wdata,
    input  logic          i_accept,
    input  logic [31:0]   i_sample_time,
    input  logic [9:0]    i_glucose,
    input  logic          i_glucose_valid,
    input  logic          i_is_start,
    input  logic          i_series_end,
    output t_result       o_res0,
    output t_result       o_res1,
    output logic [1:0]    o_res_cnt
);

    logic [19:0] r_win_sec;
    logic [15:0] r_index,  n_index;
    logic        r_open,   n_open;
    logic [32:0] r_end,    n_end;
    t_best       r_best,   n_best;

    logic        in_win;
    logic        emit_a;
    logic        emit_b;
    logic        open_mid;
    t_best       best_a;
    t_best       best_b;

    always_comb begin
        in_win   = r_open && ({1'b0, i_sample_time} <= r_end);
        best_a   = in_win ? take_sample(r_best, r_index, i_glucose, i_glucose_valid)
                          : r_best;
        emit_a   = r_open && (!in_win || i_is_start);
        open_mid = i_is_start || (r_open && !emit_a);
        best_b   = best_a;
        n_end    = r_end;
        if (i_is_start) begin
            best_b.glucose = 10'd0;
            best_b.valid   = 1'b0;
            best_b.index   = r_index;
            best_b = take_sample(best_b, r_index, i_glucose, i_glucose_valid);
            n_end  = {1'b0, i_sample_time} + {13'd0, r_win_sec};
        end
        emit_b = i_series_end && open_mid;
        n_open = open_mid && !i_series_end;
        n_best = best_b;
        if (i_series_end) begin
            n_index = 16'd0;
        end else if (r_index < IDX_CAP) begin
            n_index = r_index + 16'd1;
        end else begin
            n_index = r_index;
        end

        o_res0    = emit_a ? make_result(best_a, !emit_b) : make_result(best_b, 1'b1);
        o_res1    = make_result(best_b, 1'b1);
        o_res_cnt = i_accept ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_sec <= 20'd14400;
            r_index   <= '0;
            r_open    <= 1'b0;
            r_end     <= '0;
            r_best    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_win_sec <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_index <= n_index;
                r_open  <= n_open;
                r_end   <= n_end;
                r_best  <= n_best;
            end
        end
    end

`ifndef SYNTHESIS
    a_two_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_cnt == 2'd2) |-> (i_is_start && i_series_end && r_open))
        else $error("two results without start and series end");
    a_series_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_series_end) |=> (!r_open && r_index == 16'd0))
        else $error("series end left window open or index nonzero");
`endif

endmodule

[sv/wmas_out_fifo.sv]
// Small result queue; takes up to two results per cycle, releases one per transfer.
// Depends on wmas_pkg.
module wmas_out_fifo import wmas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_res0,
    input  t_result     i_res1,
    input  logic [1:0]  i_push_cnt,
    output logic        o_room2,
    output logic        o_valid,
    output t_result     o_data,
    input  logic        i_pop
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wptr, n_wptr;
    logic [FIFO_AW-1:0]    r_rptr, n_rptr;
    logic [FIFO_CW-1:0]    r_count, n_count;
    logic                  pop;
    logic [FIFO_AW-1:0]    wptr1;

    always_comb begin
        pop     = i_pop && (r_count != '0);
        wptr1   = r_wptr + FIFO_AW'(1);
        n_wptr  = r_wptr + FIFO_AW'(i_push_cnt);
        n_rptr  = r_rptr + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push_cnt) - FIFO_CW'(pop);
        o_room2 = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> (FIFO_CW'(i_push_cnt) + r_count <= FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue overflow");
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt == 2'd0 && !pop) |=> $stable(r_count))
        else $error("queue count moved without push or pop");
`endif

endmodule
